/* rtl/sso_pkg.sv */
// shared types and constants for the strahler/shreve orderer
// used by sso_ctrl, sso_datapath and the top level, no dependencies
package sso_pkg;

    localparam int MAX_STREAMS_DEF = 1024;
    localparam int MAX_TRIBS_DEF   = 5;
    localparam int ID_W            = 10;
    localparam int CNT_W           = 3;
    localparam int ORD_W           = 5;
    localparam int MAG_W           = 11;
    localparam int IN_TRIBS        = 5;
    localparam int ORDER_MAX       = 15;
    localparam int MAG_MAX         = 1023;
    localparam int RES_W           = ORD_W + MAG_W;
    localparam int IN_DATA_W       = 80;
    localparam int OUT_DATA_W      = 32;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_RUN   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    typedef enum logic [3:0] {
        ST_CLR_RST,
        ST_IDLE,
        ST_Q_WAIT,
        ST_RESP,
        ST_CLR_RUN,
        ST_SPR_RD,
        ST_SPR_WAIT,
        ST_NODE,
        ST_NODE_WAIT,
        ST_TRIB,
        ST_TRIB_WAIT,
        ST_WRITE
    } sso_state_t;

    typedef struct packed {
        logic load;
        logic q_read;
        logic q_latch;
        logic out_pop;
        logic clr_init;
        logic clr_step;
        logic run_start;
        logic spr_read;
        logic spr_latch;
        logic next_spring;
        logic node_read;
        logic node_latch;
        logic trib_read;
        logic trib_acc;
        logic node_write;
    } sso_cmd_t;

    typedef struct packed {
        logic out_valid;
        logic clr_last;
        logic spr_done;
        logic cur_ok;
        logic leaf;
        logic trib_ok;
        logic trib_unset;
        logic trib_last;
    } sso_stat_t;

endpackage

/* rtl/sso_ram.sv */
// generic simple dual port ram, one write and one registered read port
// no dependencies
module sso_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/sso_ctrl.sv */
// sequencer for loads, queries, clearing passes and the ordering walk
// depends on sso_pkg
module sso_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        req_type,
    input  logic              out_ready,
    input  sso_pkg::sso_stat_t stat,
    output logic              in_ready,
    output sso_pkg::sso_cmd_t  cmd
);

    sso_pkg::sso_state_t state_reg, state_next;
    logic acc;

    assign in_ready = (state_reg == sso_pkg::ST_IDLE) && !stat.out_valid;
    assign acc      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sso_pkg::ST_CLR_RST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sso_pkg::ST_CLR_RST:
                if (stat.clr_last) state_next = sso_pkg::ST_IDLE;
            sso_pkg::ST_IDLE:
                if (acc)
                begin
                    priority if (req_type == sso_pkg::REQ_RUN)
                        state_next = sso_pkg::ST_CLR_RUN;
                    else if (req_type == sso_pkg::REQ_QUERY)
                        state_next = sso_pkg::ST_Q_WAIT;
                    else
                        state_next = sso_pkg::ST_IDLE;
                end
            sso_pkg::ST_Q_WAIT:
                state_next = sso_pkg::ST_RESP;
            sso_pkg::ST_RESP:
                if (out_ready) state_next = sso_pkg::ST_IDLE;
            sso_pkg::ST_CLR_RUN:
                if (stat.clr_last) state_next = sso_pkg::ST_SPR_RD;
            sso_pkg::ST_SPR_RD:
                state_next = stat.spr_done ? sso_pkg::ST_IDLE : sso_pkg::ST_SPR_WAIT;
            sso_pkg::ST_SPR_WAIT:
                state_next = sso_pkg::ST_NODE;
            sso_pkg::ST_NODE:
                state_next = stat.cur_ok ? sso_pkg::ST_NODE_WAIT : sso_pkg::ST_SPR_RD;
            sso_pkg::ST_NODE_WAIT:
                state_next = stat.leaf ? sso_pkg::ST_WRITE : sso_pkg::ST_TRIB;
            sso_pkg::ST_TRIB:
                state_next = stat.trib_ok ? sso_pkg::ST_TRIB_WAIT : sso_pkg::ST_SPR_RD;
            sso_pkg::ST_TRIB_WAIT:
            begin
                priority if (stat.trib_unset) state_next = sso_pkg::ST_SPR_RD;
                else if (stat.trib_last)      state_next = sso_pkg::ST_WRITE;
                else                          state_next = sso_pkg::ST_TRIB;
            end
            sso_pkg::ST_WRITE:
                state_next = sso_pkg::ST_NODE;
            default:
                state_next = sso_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            sso_pkg::ST_CLR_RST:
            begin
                cmd.clr_step = 1'b1;
            end
            sso_pkg::ST_IDLE:
            begin
                cmd.load     = acc && (req_type == sso_pkg::REQ_LOAD);
                cmd.clr_init = acc && (req_type == sso_pkg::REQ_RUN);
                cmd.q_read   = acc && (req_type == sso_pkg::REQ_QUERY);
            end
            sso_pkg::ST_Q_WAIT:
                cmd.q_latch = 1'b1;
            sso_pkg::ST_RESP:
                cmd.out_pop = out_ready;
            sso_pkg::ST_CLR_RUN:
            begin
                cmd.clr_step  = 1'b1;
                cmd.run_start = stat.clr_last;
            end
            sso_pkg::ST_SPR_RD:
                cmd.spr_read = !stat.spr_done;
            sso_pkg::ST_SPR_WAIT:
                cmd.spr_latch = 1'b1;
            sso_pkg::ST_NODE:
            begin
                cmd.node_read   = stat.cur_ok;
                cmd.next_spring = !stat.cur_ok;
            end
            sso_pkg::ST_NODE_WAIT:
                cmd.node_latch = 1'b1;
            sso_pkg::ST_TRIB:
            begin
                cmd.trib_read   = stat.trib_ok;
                cmd.next_spring = !stat.trib_ok;
            end
            sso_pkg::ST_TRIB_WAIT:
            begin
                cmd.trib_acc    = !stat.trib_unset;
                cmd.next_spring = stat.trib_unset;
            end
            sso_pkg::ST_WRITE:
                cmd.node_write = 1'b1;
            default:
                cmd = '0;
        endcase
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (state_reg == sso_pkg::ST_IDLE))
        else $error("input ready outside idle");
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        stat.out_valid |-> !in_ready)
        else $error("input ready while a result is pending");
    a_trib_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sso_pkg::ST_TRIB_WAIT) |-> ($past(state_reg) == sso_pkg::ST_TRIB))
        else $error("tributary accumulate without a read");
    a_clr_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sso_pkg::ST_CLR_RUN && stat.clr_last) |=>
            (state_reg == sso_pkg::ST_SPR_RD))
        else $error("run did not start after clearing");

endmodule

/* rtl/sso_datapath.sv */
// network tables, result table, spring list and the settle arithmetic
// depends on sso_pkg and sso_ram
module sso_datapath #(
    parameter int MAX_STREAMS = sso_pkg::MAX_STREAMS_DEF,
    parameter int MAX_TRIBS   = sso_pkg::MAX_TRIBS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [sso_pkg::ID_W-1:0]        cfg_wdata,
    input  logic [sso_pkg::IN_DATA_W-1:0]   in_data,
    input  sso_pkg::sso_cmd_t               cmd,
    output sso_pkg::sso_stat_t              stat,
    output logic                            out_valid,
    output logic [sso_pkg::OUT_DATA_W-1:0]  out_data
);

    localparam int AW   = $clog2(MAX_STREAMS);
    localparam int TIW  = (MAX_TRIBS > 1) ? $clog2(MAX_TRIBS) : 1;
    localparam int TW   = sso_pkg::ID_W * MAX_TRIBS;
    localparam int NW   = sso_pkg::ID_W + sso_pkg::CNT_W + TW;
    localparam int IDW  = sso_pkg::ID_W;

    logic [IDW-1:0]               stream_count_reg;
    logic [IDW-1:0]               in_sid, in_ds;
    logic [sso_pkg::CNT_W-1:0]    in_cnt, in_cnt_clamp;
    logic [IDW-1:0]               in_trib [sso_pkg::IN_TRIBS];
    logic [TW-1:0]                in_tribs_packed;

    logic [AW:0]                  clr_cnt_reg;
    logic [AW:0]                  spring_total_reg;
    logic [AW:0]                  spr_idx_reg;
    logic [AW:0]                  steps_reg;
    logic [IDW-1:0]               cur_reg;
    logic [IDW-1:0]               ds_reg;
    logic [sso_pkg::CNT_W-1:0]    n_reg;
    logic [TW-1:0]                tribs_reg;
    logic [TIW-1:0]               i_reg;
    logic [3:0]                   best_reg;
    logic [3:0]                   num_reg;
    logic [9:0]                   sum_reg;
    logic [IDW-1:0]               q_sid_reg;
    logic                         q_ok_reg;
    logic                         out_valid_reg;
    logic [sso_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic [NW-1:0]                net_rdata;
    logic [sso_pkg::RES_W-1:0]    res_rdata, res_wdata;
    logic [IDW-1:0]               spr_rdata;
    logic [AW-1:0]                res_waddr, res_raddr;
    logic                         res_we;
    logic [IDW-1:0]               cur_trib;
    logic [3:0]                   o_val, best_fin;
    logic [11:0]                  sum_add;
    logic                         spring_load;

    function automatic logic id_ok(input logic [IDW-1:0] id, input logic [IDW-1:0] cnt);
        id_ok = (id != '0) && (id <= cnt) && (32'(id) < MAX_STREAMS);
    endfunction

    assign in_sid = in_data[9:0];
    assign in_ds  = in_data[19:10];
    assign in_cnt = in_data[22:20];
    always_comb
    begin
        for (int k = 0; k < sso_pkg::IN_TRIBS; k++)
        begin
            in_trib[k] = in_data[23 + k*IDW +: IDW];
        end
    end
    assign in_cnt_clamp = (32'(in_cnt) > MAX_TRIBS) ? sso_pkg::CNT_W'(MAX_TRIBS) : in_cnt;

    always_comb
    begin
        in_tribs_packed = '0;
        for (int k = 0; k < MAX_TRIBS; k++)
        begin
            if (k < sso_pkg::IN_TRIBS)
            begin
                in_tribs_packed[k*IDW +: IDW] = in_trib[k];
            end
        end
    end

    assign spring_load = cmd.load && (in_cnt_clamp == '0)
                         && (spring_total_reg < (AW+1)'(MAX_STREAMS));

    sso_ram #(.WIDTH(NW), .DEPTH(MAX_STREAMS)) u_net_ram (
        .clk   (clk),
        .we    (cmd.load && id_ok(in_sid, stream_count_reg)),
        .waddr (AW'(in_sid)),
        .wdata ({in_tribs_packed, in_cnt_clamp, in_ds}),
        .re    (cmd.node_read),
        .raddr (AW'(cur_reg)),
        .rdata (net_rdata)
    );

    sso_ram #(.WIDTH(IDW), .DEPTH(MAX_STREAMS)) u_spring_ram (
        .clk   (clk),
        .we    (spring_load && id_ok(in_sid, stream_count_reg)),
        .waddr (spring_total_reg[AW-1:0]),
        .wdata (in_sid),
        .re    (cmd.spr_read),
        .raddr (spr_idx_reg[AW-1:0]),
        .rdata (spr_rdata)
    );

    assign cur_trib = tribs_reg[i_reg*IDW +: IDW];

    assign best_fin = (num_reg > 4'd1 && best_reg < 4'(sso_pkg::ORDER_MAX))
                      ? best_reg + 4'd1 : best_reg;

    always_comb
    begin
        res_we    = cmd.clr_step || cmd.node_write;
        res_waddr = cmd.clr_step ? clr_cnt_reg[AW-1:0] : AW'(cur_reg);
        res_wdata = cmd.clr_step ? '1 : {1'b0, best_fin, 1'b0, sum_reg};
        res_raddr = cmd.q_read ? AW'(in_sid) : AW'(cur_trib);
    end

    sso_ram #(.WIDTH(sso_pkg::RES_W), .DEPTH(MAX_STREAMS)) u_res_ram (
        .clk   (clk),
        .we    (res_we),
        .waddr (res_waddr),
        .wdata (res_wdata),
        .re    (cmd.q_read || cmd.trib_read),
        .raddr (res_raddr),
        .rdata (res_rdata)
    );

    assign o_val   = res_rdata[14:11];
    assign sum_add = 12'(sum_reg) + 12'(res_rdata[9:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_count_reg <= '0;
            clr_cnt_reg      <= '0;
            spring_total_reg <= '0;
            spr_idx_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wen)
            begin
                stream_count_reg <= cfg_wdata;
            end
            if (cmd.clr_init)
            begin
                clr_cnt_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (spring_load && id_ok(in_sid, stream_count_reg))
            begin
                spring_total_reg <= spring_total_reg + 1'b1;
            end
            if (cmd.run_start)
            begin
                spr_idx_reg <= '0;
            end
            else if (cmd.next_spring)
            begin
                spr_idx_reg <= spr_idx_reg + 1'b1;
            end
            if (cmd.q_latch)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cmd.out_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.q_read)
        begin
            q_sid_reg <= in_sid;
            q_ok_reg  <= id_ok(in_sid, stream_count_reg);
        end
        if (cmd.q_latch)
        begin
            out_data_reg <= {6'd0,
                             q_ok_reg ? {res_rdata[sso_pkg::MAG_W-1:0],
                                         res_rdata[sso_pkg::RES_W-1 -: sso_pkg::ORD_W]}
                                      : {sso_pkg::RES_W{1'b1}},
                             q_sid_reg};
        end
        if (cmd.spr_latch)
        begin
            cur_reg   <= spr_rdata;
            steps_reg <= '0;
        end
        else if (cmd.node_write)
        begin
            cur_reg   <= ds_reg;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.node_latch)
        begin
            ds_reg    <= net_rdata[IDW-1:0];
            n_reg     <= net_rdata[IDW +: sso_pkg::CNT_W];
            tribs_reg <= net_rdata[NW-1 -: TW];
            i_reg     <= '0;
            num_reg   <= '0;
            best_reg  <= (net_rdata[IDW +: sso_pkg::CNT_W] == '0) ? 4'd1 : 4'd0;
            sum_reg   <= (net_rdata[IDW +: sso_pkg::CNT_W] == '0) ? 10'd1 : 10'd0;
        end
        else if (cmd.trib_acc)
        begin
            i_reg <= i_reg + 1'b1;
            if (o_val > best_reg)
            begin
                best_reg <= o_val;
                num_reg  <= 4'd1;
            end
            else if (o_val == best_reg)
            begin
                num_reg <= num_reg + 4'd1;
            end
            sum_reg <= (sum_add > 12'(sso_pkg::MAG_MAX)) ? 10'(sso_pkg::MAG_MAX)
                                                         : sum_add[9:0];
        end
    end

    always_comb
    begin
        stat.out_valid  = out_valid_reg;
        stat.clr_last   = (clr_cnt_reg == (AW+1)'(MAX_STREAMS - 1));
        stat.spr_done   = (spr_idx_reg >= spring_total_reg);
        stat.cur_ok     = id_ok(cur_reg, stream_count_reg)
                          && (steps_reg < (AW+1)'(MAX_STREAMS));
        stat.leaf       = (net_rdata[IDW +: sso_pkg::CNT_W] == '0);
        stat.trib_ok    = id_ok(cur_trib, stream_count_reg);
        stat.trib_unset = res_rdata[sso_pkg::RES_W-1] || res_rdata[sso_pkg::MAG_W-1];
        stat.trib_last  = (4'(i_reg) + 4'd1 == 4'(n_reg));
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/strahler_shreve_orderer.sv */
// top level of the strahler order and shreve magnitude block
// depends on sso_pkg, sso_ctrl, sso_datapath, sso_ram
// load: written as the beat is taken; query: m_tvalid set by ST_Q_WAIT, next beat after pop
// run: a clearing pass over all MAX_STREAMS entries, then per spring a spring list read
// and per segment a node read, tributary reads and a write, one result ram access at a time
// reset: clears all MAX_STREAMS entries with s_tready low; config writes still taken
module strahler_shreve_orderer #(
    parameter int MAX_STREAMS = sso_pkg::MAX_STREAMS_DEF,
    parameter int MAX_TRIBS   = sso_pkg::MAX_TRIBS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wen,
    input  logic [sso_pkg::ID_W-1:0]       cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // stream_id, downstream_id, trib_count, trib_a..trib_e, zero pad
    input  logic [sso_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // result_stream, strahler_order, shreve_magnitude, zero pad
    output logic [sso_pkg::OUT_DATA_W-1:0] m_tdata
);

    sso_pkg::sso_cmd_t  cmd;
    sso_pkg::sso_stat_t stat;

    sso_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .req_type  (s_tuser),
        .out_ready (m_tready),
        .stat      (stat),
        .in_ready  (s_tready),
        .cmd       (cmd)
    );

    sso_datapath #(.MAX_STREAMS(MAX_STREAMS), .MAX_TRIBS(MAX_TRIBS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_data  (m_tdata)
    );

endmodule
